>>> hdl/sspq_pkg.sv
`timescale 1ns / 1ps
// Shared codes and types for the stable sorted priority queue.
// No dependencies; imported by the result interface and the queue core.
package sspq_pkg;

   localparam int STATUS_WIDTH = 2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_PLACE = 5'b00100,
      ST_POP   = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

endpackage

>>> hdl/sspq_req_if.sv
`timescale 1ns / 1ps
// Command channel of the priority queue: insert or pop items.
// Valid/ready handshake; no package dependency.
interface sspq_req_if #(
   parameter int HANDLE_WIDTH = 16,
   parameter int COST_WIDTH   = 12
);
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [HANDLE_WIDTH-1:0] node_handle;
   logic                    parent_present;
   logic [HANDLE_WIDTH-1:0] parent_handle;
   logic [COST_WIDTH-1:0]   parent_cost;
   logic [COST_WIDTH-1:0]   estimate;

   modport source (
      output valid, cmd, node_handle, parent_present, parent_handle, parent_cost,
             estimate,
      input  ready
   );
   modport sink (
      input  valid, cmd, node_handle, parent_present, parent_handle, parent_cost,
             estimate,
      output ready
   );
endinterface

>>> hdl/sspq_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the priority queue: one item per command.
// Valid/ready handshake; status width from sspq_pkg.
interface sspq_rsp_if import sspq_pkg::*; #(
   parameter int HANDLE_WIDTH = 16,
   parameter int COST_WIDTH   = 12
);
   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic                    pop_valid;
   logic [HANDLE_WIDTH-1:0] out_node;
   logic [HANDLE_WIDTH-1:0] out_parent;
   logic [COST_WIDTH-1:0]   out_cost;
   logic [COST_WIDTH-1:0]   out_estimate;
   logic [COST_WIDTH:0]     out_key;
   logic [31:0]             inserted_total;

   modport source (
      output valid, status, pop_valid, out_node, out_parent, out_cost, out_estimate,
             out_key, inserted_total,
      input  ready
   );
   modport sink (
      input  valid, status, pop_valid, out_node, out_parent, out_cost, out_estimate,
             out_key, inserted_total,
      output ready
   );
endinterface

>>> hdl/sspq_store.sv
`timescale 1ns / 1ps
// Entry memory of the priority queue: one write port, one read port,
// registered read data. No package dependency.
module sspq_store #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 57
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/stable_sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// Stable sorted priority queue: entries kept in key order in a circular buffer.
// A pop ends in ST_POP. An insert into an empty queue ends in ST_IDLE; else ST_SCAN
// moves each stored entry with a larger key up a slot (one memory read/write per
// entry) and ST_SCAN or ST_PLACE writes the new entry. Pop on empty and insert into
// full end in ST_IDLE. Result is registered. One command in flight at a time.
// Synchronous reset empties the queue and clears the insert count; no memory clear.
module stable_sorted_priority_queue_core import sspq_pkg::*; #(
   parameter int CAPACITY     = 256,
   parameter int HANDLE_WIDTH = 16,
   parameter int COST_WIDTH   = 12
) (
   input logic       clock,
   input logic       reset,
   sspq_req_if.sink  req_bus,
   sspq_rsp_if.source rsp_bus
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int KEY_W = COST_WIDTH + 1;
   localparam int ENT_W = 2 * HANDLE_WIDTH + 2 * COST_WIDTH + KEY_W;

   localparam logic [PTR_W-1:0]      LAST_IDX = PTR_W'(CAPACITY - 1);
   localparam logic [OCC_W-1:0]      FULL_OCC = OCC_W'(CAPACITY);
   localparam logic [COST_WIDTH-1:0] COST_MAX = {COST_WIDTH{1'b1}};

   typedef struct packed {
      logic [HANDLE_WIDTH-1:0] node;
      logic [HANDLE_WIDTH-1:0] parent;
      logic [COST_WIDTH-1:0]   cost;
      logic [COST_WIDTH-1:0]   est;
      logic [KEY_W-1:0]        key;
   } entry_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic                    pop_valid;
      entry_type               ent;
      logic [31:0]             total;
   } result_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_IDX : p - 1'b1;
   endfunction

   state_type  state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] cur_ff, cur_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [OCC_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      count_ff, count_in;
   entry_type        new_ff, new_in;
   logic             rsp_valid_ff;
   result_type       rsp_data_ff;
   result_type       pend_ff;

   entry_type        in_entry;
   entry_type        mem_q;
   logic [ENT_W-1:0] mem_rd_data;
   logic             wr_en, rd_en;
   logic [PTR_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data;
   logic             fin;
   result_type       fin_data;
   logic             req_fire, out_free, greater;
   logic [COST_WIDTH-1:0] cost_calc;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign mem_q         = entry_type'(mem_rd_data);
   assign greater       = (mem_q.key > new_ff.key);

   // cost saturates at the field maximum; no parent means cost 0
   always_comb begin
      if (!req_bus.parent_present) begin
         cost_calc = '0;
      end else if (req_bus.parent_cost == COST_MAX) begin
         cost_calc = COST_MAX;
      end else begin
         cost_calc = req_bus.parent_cost + 1'b1;
      end
      in_entry.node   = req_bus.node_handle;
      in_entry.parent = req_bus.parent_present ? req_bus.parent_handle : '0;
      in_entry.cost   = cost_calc;
      in_entry.est    = req_bus.estimate;
      in_entry.key    = {1'b0, cost_calc} + {1'b0, req_bus.estimate};
   end

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      cur_in   = cur_ff;
      occ_in   = occ_ff;
      cnt_in   = cnt_ff;
      count_in = count_ff;
      new_in   = new_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_inc(cur_ff);
      wr_data  = new_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      fin      = 1'b0;
      fin_data = '0;
      fin_data.total = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               new_in = in_entry;
               if (req_bus.cmd == CMD_POP) begin
                  if (occ_ff == '0) begin
                     fin             = 1'b1;
                     fin_data.status = STATUS_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = ST_POP;
                  end
               end else if (occ_ff == FULL_OCC) begin
                  fin             = 1'b1;
                  fin_data.status = STATUS_FULL;
               end else if (occ_ff == '0) begin
                  wr_en          = 1'b1;
                  wr_addr        = ptr_inc(tail_ff);
                  wr_data        = in_entry;
                  tail_in        = ptr_inc(tail_ff);
                  occ_in         = occ_ff + 1'b1;
                  count_in       = count_ff + 1'b1;
                  fin            = 1'b1;
                  fin_data.total = count_ff + 1'b1;
               end else begin
                  // walk down from the tail, moving larger keys up one slot
                  rd_en    = 1'b1;
                  rd_addr  = tail_ff;
                  cur_in   = tail_ff;
                  cnt_in   = occ_ff;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (greater) begin
               wr_en   = 1'b1;
               wr_addr = ptr_inc(cur_ff);
               wr_data = mem_q;
               cur_in  = ptr_dec(cur_ff);
               if (cnt_ff > OCC_W'(1)) begin
                  cnt_in  = cnt_ff - 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = ptr_dec(cur_ff);
               end else begin
                  state_in = ST_PLACE;
               end
            end else begin
               wr_en          = 1'b1;
               tail_in        = ptr_inc(tail_ff);
               occ_in         = occ_ff + 1'b1;
               count_in       = count_ff + 1'b1;
               fin            = 1'b1;
               fin_data.total = count_ff + 1'b1;
            end
         end
         ST_PLACE: begin
            wr_en          = 1'b1;
            tail_in        = ptr_inc(tail_ff);
            occ_in         = occ_ff + 1'b1;
            count_in       = count_ff + 1'b1;
            fin            = 1'b1;
            fin_data.total = count_ff + 1'b1;
         end
         ST_POP: begin
            fin                = 1'b1;
            fin_data.pop_valid = 1'b1;
            fin_data.ent       = mem_q;
            head_in            = ptr_inc(head_ff);
            occ_in             = occ_ff - 1'b1;
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // park the result if the output register is still occupied
      if (fin) begin
         state_in = out_free ? ST_IDLE : ST_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= LAST_IDX;
         occ_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
         count_ff <= count_in;
         if (fin && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if ((state_ff == ST_HOLD) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      new_ff <= new_in;
      if (fin) begin
         pend_ff <= fin_data;
      end
      if (fin && out_free) begin
         rsp_data_ff <= fin_data;
      end else if ((state_ff == ST_HOLD) && out_free) begin
         rsp_data_ff <= pend_ff;
      end
   end

   sspq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ENT_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_data_ff.status;
   assign rsp_bus.pop_valid      = rsp_data_ff.pop_valid;
   assign rsp_bus.out_node       = rsp_data_ff.ent.node;
   assign rsp_bus.out_parent     = rsp_data_ff.ent.parent;
   assign rsp_bus.out_cost       = rsp_data_ff.ent.cost;
   assign rsp_bus.out_estimate   = rsp_data_ff.ent.est;
   assign rsp_bus.out_key        = rsp_data_ff.ent.key;
   assign rsp_bus.inserted_total = rsp_data_ff.total;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_OCC)
      else $error("occupancy above capacity");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff != '0) && (occ_ff != FULL_OCC))
      else $error("scan with no entries left or on a full queue");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |=> (occ_ff == $past(occ_ff) - OCC_W'(1)))
      else $error("pop did not release an entry");

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("result parked while output register empty");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.pop_valid) |-> (rsp_data_ff.status == STATUS_OK))
      else $error("popped entry with error status");

endmodule
